// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds its value into the cycle after the condition.
`define ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    localparam int FIELD_W   = 44;
    localparam int WIDE_W    = 48;
    localparam int ADDR_BITS = 44;

    localparam logic [WIDE_W-1:0] ADDR_MASK =
        {{(WIDE_W-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NULL       = 3'd1,
        STS_MISALIGNED = 3'd2,
        STS_NOT_FOUND  = 3'd3,
        STS_BAD_SIZE   = 3'd4,
        STS_NO_SPACE   = 3'd5,
        STS_FULL       = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_SCAN,
        S_FIT,
        S_ISH,
        S_INS,
        S_RSH,
        S_RESP
    } state_t;

    typedef struct packed {
        logic    load;
        logic    cand_adv;
        logic    wr_en;
        logic    wr_new;
        logic    out_load;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic op_release;
        logic bad_size;
        logic null_addr;
        logic misaligned;
        logic gap_fits;
        logic match;
        logic no_space;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: scan, insert shift and remove shift over the region table.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl #(
    parameter int MAX_REGIONS = 32,
    parameter int CW = 6,
    parameter int IW = 5
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  ffra_pkg::dp_status_t    dps,
    output ffra_pkg::cmd_t          cmd,
    output logic [IW-1:0]           rd_idx,
    output logic [IW-1:0]           wr_idx
);
    import ffra_pkg::*;

    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_REGIONS);

    state_t         state_reg, state_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  k_reg, k_next;
    status_t        sts_reg, sts_next;
    logic [CW-1:0]  rd_cnt;
    logic [CW:0]    k_plus2;
    logic [CW:0]    pos_plus1;

    assign k_plus2   = {1'b0, k_reg} + (CW+1)'(2);
    assign pos_plus1 = {1'b0, pos_reg} + (CW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            sts_reg   <= STS_OK;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            sts_reg   <= sts_next;
        end
    end

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        sts_next   = sts_reg;
        case (state_reg)
            S_IDLE:
            begin
                pos_next = '0;
                if (in_valid)
                    state_next = S_PRE;
            end
            S_PRE:
            begin
                if (!dps.op_release && dps.bad_size)
                begin
                    sts_next   = STS_BAD_SIZE;
                    state_next = S_RESP;
                end
                else if (dps.op_release && dps.null_addr)
                begin
                    sts_next   = STS_NULL;
                    state_next = S_RESP;
                end
                else if (dps.op_release && dps.misaligned)
                begin
                    sts_next   = STS_MISALIGNED;
                    state_next = S_RESP;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!dps.op_release)
                begin
                    if (pos_reg == n_reg || dps.gap_fits)
                        state_next = S_FIT;
                    else
                        pos_next = pos_reg + CW'(1);
                end
                else if (pos_reg == n_reg)
                begin
                    sts_next   = STS_NOT_FOUND;
                    state_next = S_RESP;
                end
                else if (dps.match)
                begin
                    k_next = pos_reg;
                    if (pos_plus1 < {1'b0, n_reg})
                        state_next = S_RSH;
                    else
                    begin
                        n_next     = n_reg - CW'(1);
                        sts_next   = STS_OK;
                        state_next = S_RESP;
                    end
                end
                else
                    pos_next = pos_reg + CW'(1);
            end
            S_FIT:
            begin
                if (dps.no_space)
                begin
                    sts_next   = STS_NO_SPACE;
                    state_next = S_RESP;
                end
                else if (n_reg == FULL_CNT)
                begin
                    sts_next   = STS_FULL;
                    state_next = S_RESP;
                end
                else if (n_reg == pos_reg)
                    state_next = S_INS;
                else
                begin
                    k_next     = n_reg;
                    state_next = S_ISH;
                end
            end
            S_ISH:
            begin
                if (k_reg - CW'(1) == pos_reg)
                    state_next = S_INS;
                else
                    k_next = k_reg - CW'(1);
            end
            S_INS:
            begin
                n_next     = n_reg + CW'(1);
                sts_next   = STS_OK;
                state_next = S_RESP;
            end
            S_RSH:
            begin
                if (k_plus2 < {1'b0, n_reg})
                    k_next = k_reg + CW'(1);
                else
                begin
                    n_next     = n_reg - CW'(1);
                    sts_next   = STS_OK;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (dps.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd        = '0;
        cmd.status = sts_reg;
        rd_cnt     = '0;
        wr_idx     = '0;
        case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_PRE:
                rd_cnt = '0;
            S_SCAN:
            begin
                if (!dps.op_release && !(pos_reg == n_reg || dps.gap_fits))
                    cmd.cand_adv = 1'b1;
                rd_cnt = pos_reg + CW'(1);
            end
            S_FIT:
                rd_cnt = n_reg - CW'(1);
            S_ISH:
            begin
                cmd.wr_en = 1'b1;
                wr_idx    = k_reg[IW-1:0];
                rd_cnt    = k_reg - CW'(2);
            end
            S_INS:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_new = 1'b1;
                wr_idx     = pos_reg[IW-1:0];
            end
            S_RSH:
            begin
                cmd.wr_en = 1'b1;
                wr_idx    = k_reg[IW-1:0];
                rd_cnt    = k_plus2[CW-1:0];
            end
            S_RESP:
                cmd.out_load = dps.out_free;
            default:
                rd_cnt = '0;
        endcase
    end

    // First remove read happens on the match cycle
    assign rd_idx   = (state_reg == S_SCAN && dps.op_release && dps.match) ?
                      pos_plus1[IW-1:0] : rd_cnt[IW-1:0];
    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ffra_datapath.sv =====
// ----------------------------------------------------------------------------
// ffra_datapath
// Window registers, region table memory, candidate address and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_datapath #(
    parameter int MAX_REGIONS = 32,
    parameter int PAGE_SHIFT = 13,
    parameter int IW = 5
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire                             cfg_index,
    input  wire [ffra_pkg::FIELD_W-1:0]     cfg_data,
    input  wire                             op,
    input  wire [ffra_pkg::FIELD_W-1:0]     size_bytes,
    input  wire [ffra_pkg::FIELD_W-1:0]     region_address,
    input  ffra_pkg::cmd_t                  cmd,
    input  wire [IW-1:0]                    rd_idx,
    input  wire [IW-1:0]                    wr_idx,
    output ffra_pkg::dp_status_t            dps,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [2:0]                      status,
    output logic [ffra_pkg::FIELD_W-1:0]    granted_address
);
    import ffra_pkg::*;

    localparam logic [WIDE_W-1:0] PAGE_BYTES = WIDE_W'(1) << PAGE_SHIFT;
    localparam logic [WIDE_W-1:0] PAGE_LOW   = PAGE_BYTES - WIDE_W'(1);

    logic [FIELD_W-1:0]  base_reg, len_reg;
    logic                op_reg;
    logic [WIDE_W-1:0]   size_reg, cand_reg, end_reg;
    logic [FIELD_W-1:0]  addr_reg;
    logic [2*WIDE_W-1:0] mem [MAX_REGIONS];
    logic [2*WIDE_W-1:0] rd_reg;
    logic [WIDE_W-1:0]   rd_start, rd_span;
    logic [WIDE_W-1:0]   cand_size;
    logic [WIDE_W-1:0]   size_round;
    logic                out_valid_reg;
    status_t             status_reg;
    logic [FIELD_W-1:0]  grant_reg;

    assign rd_start   = rd_reg[2*WIDE_W-1:WIDE_W];
    assign rd_span    = rd_reg[WIDE_W-1:0];
    assign cand_size  = cand_reg + size_reg;
    assign size_round = ({{(WIDE_W-FIELD_W){1'b0}}, size_bytes} + PAGE_LOW) & ~PAGE_LOW;

    // Window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BASE)
                base_reg <= cfg_data;
            else
                len_reg <= cfg_data;
        end
    end

    // Latch request and advance the candidate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            size_reg <= size_round;
            addr_reg <= region_address;
            cand_reg <= {{(WIDE_W-FIELD_W){1'b0}}, base_reg};
            end_reg  <= {{(WIDE_W-FIELD_W){1'b0}}, base_reg}
                      + {{(WIDE_W-FIELD_W){1'b0}}, len_reg};
        end
        else if (cmd.cand_adv)
            cand_reg <= rd_start + rd_span;
    end

    // Region table
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_idx] <= cmd.wr_new ? {cand_reg, size_reg + PAGE_BYTES} : rd_reg;
        rd_reg <= mem[rd_idx];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.status;
            grant_reg  <= (op_reg == OP_ALLOC && cmd.status == STS_OK) ?
                          FIELD_W'(cand_reg & ADDR_MASK) : '0;
        end
    end

    // Status to the sequencer
    always_comb
    begin
        dps.op_release = (op_reg == OP_RELEASE);
        dps.bad_size   = (size_reg == '0)
                      || (size_reg > {{(WIDE_W-FIELD_W){1'b0}}, len_reg});
        dps.null_addr  = (addr_reg == '0);
        dps.misaligned = (addr_reg[PAGE_SHIFT-1:0] != '0);
        dps.gap_fits   = (cand_size < rd_start);
        dps.match      = (rd_start == {{(WIDE_W-FIELD_W){1'b0}}, addr_reg});
        dps.no_space   = (cand_size >= end_reg);
        dps.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;

endmodule

`default_nettype wire

// ===== rtl/first_fit_region_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit allocator over an address-sorted region table in a window.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------
//  request   | in_valid / in_stall     | op, size_bytes, region_address
//  result    | out_valid / out_stall   | status, granted_address
//  config    | cfg_we                  | cfg_index, cfg_data
//
//  A rejected size or address goes from the checks straight to the result.
//  An allocate walks the table to the first gap that fits, shifts the later
//  entries up and writes the new one; a release walks to its entry and
//  shifts any later entries down. The table memory's single read and write
//  port sets one scan step or one shift step per cycle.
//  Reset clears the fill count, so the table is empty at once.
//  A stalled result waits in the output register; the next request is taken
//  once the current one has been handed to that register.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator_core #(
    parameter int MAX_REGIONS = 32,
    parameter int PAGE_SHIFT = 13
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire                             cfg_index,
    input  wire [ffra_pkg::FIELD_W-1:0]     cfg_data,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             op,
    input  wire [ffra_pkg::FIELD_W-1:0]     size_bytes,
    input  wire [ffra_pkg::FIELD_W-1:0]     region_address,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [2:0]                      status,
    output logic [ffra_pkg::FIELD_W-1:0]    granted_address
);
    import ffra_pkg::*;

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    cmd_t          cmd;
    dp_status_t    dps;
    logic [IW-1:0] rd_idx, wr_idx;

    ffra_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .CW          (CW),
        .IW          (IW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dps      (dps),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx)
    );

    ffra_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .IW          (IW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .size_bytes      (size_bytes),
        .region_address  (region_address),
        .cmd             (cmd),
        .rd_idx          (rd_idx),
        .wr_idx          (wr_idx),
        .dps             (dps),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_address (granted_address)
    );

endmodule

`default_nettype wire

// ===== rtl/ffra_checker.sv =====
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ffra_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_stall,
    input wire                          out_valid,
    input wire                          out_stall,
    input wire [2:0]                    status,
    input wire [ffra_pkg::FIELD_W-1:0]  granted_address
);
    import ffra_pkg::*;

    // A failed result never carries an address
    `ASSERT_CLK(a_fail_no_grant, out_valid && status != STS_OK |-> granted_address == '0, "grant on failure")
    // A taken request stalls the next one in the following cycle
    `ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "request taken while busy")
    // A stalled result stays
    `ASSERT_CLK(a_out_hold_valid, out_valid && out_stall |=> out_valid, "result dropped")
    `ASSERT_HOLD(a_out_hold_status, out_valid && out_stall, status, "stalled status changed")

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .granted_address (granted_address)
);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit region allocator core against a cycle-free table model.
// Directed requests cover size limits, every status and the full table; random
// traffic then maps and unmaps regions under several windows, with bursty
// senders and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ffra_pkg::*;

    class region_scoreboard;
        localparam int NREG  = 32;
        localparam int PSH   = 13;
        localparam longint unsigned PAGE = 64'd1 << PSH;

        longint unsigned win_base;
        longint unsigned win_len;
        longint unsigned starts[$];
        longint unsigned spans[$];
        status_t         exp_status[$];
        logic [43:0]     exp_addr[$];
        int              errors;

        function new();
            win_base = 0;
            win_len  = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic idx, logic [43:0] val);
            if (idx == CFG_BASE)
                win_base = 64'(val);
            else
                win_len = 64'(val);
        endfunction

        // Predict the response to one accepted request and update the table.
        function void note_request(logic req_op, logic [43:0] sz, logic [43:0] addr);
            longint unsigned size;
            longint unsigned cand;
            longint unsigned wend;
            int              pos;
            int              hit;
            status_t         st;
            logic [43:0]     ga;
            ga = '0;
            if (req_op == OP_ALLOC) begin
                size = (64'(sz) + PAGE - 1) & ~(PAGE - 1);
                cand = win_base;
                wend = win_base + win_len;
                pos  = 0;
                if (size == 0 || size > win_len)
                    st = STS_BAD_SIZE;
                else begin
                    while (pos < starts.size() && !(cand + size < starts[pos])) begin
                        cand = starts[pos] + spans[pos];
                        pos++;
                    end
                    if (cand + size >= wend)
                        st = STS_NO_SPACE;
                    else if (starts.size() >= NREG)
                        st = STS_FULL;
                    else begin
                        st = STS_OK;
                        starts.insert(pos, cand);
                        spans.insert(pos, size + PAGE);
                        ga = cand[43:0];
                    end
                end
            end else begin
                hit = -1;
                if (addr == 0)
                    st = STS_NULL;
                else if (addr[PSH-1:0] != 0)
                    st = STS_MISALIGNED;
                else begin
                    foreach (starts[i])
                        if (hit < 0 && starts[i] == 64'(addr))
                            hit = i;
                    if (hit < 0)
                        st = STS_NOT_FOUND;
                    else begin
                        st = STS_OK;
                        starts.delete(hit);
                        spans.delete(hit);
                    end
                end
            end
            exp_status.push_back(st);
            exp_addr.push_back(ga);
        endfunction

        function void check_result(logic [2:0] st, logic [43:0] ga);
            status_t     es;
            logic [43:0] ea;
            if (exp_status.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%h", $time, st, ga);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ea = exp_addr.pop_front();
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (ga !== ea) begin
                $display("%0t: address expected %h actual %h", $time, ea, ga);
                errors++;
            end
        endfunction

        function int pending();
            return exp_status.size();
        endfunction

        // Pick a start address of a held region, or a miss if none.
        function logic [43:0] some_start();
            longint unsigned s;
            if (starts.size() == 0)
                return 44'h0002000;
            s = starts[$urandom_range(starts.size() - 1)];
            return s[43:0];
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [43:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [43:0] size_bytes;
    logic [43:0] region_address;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [43:0] granted_address;

    region_scoreboard sb;
    int               burst_left;
    int               stall_mode;

    first_fit_region_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .size_bytes(size_bytes), .region_address(region_address),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .granted_address(granted_address)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Check every accepted result at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, granted_address);
    end

    // Stall the receiver on a pattern that changes mode now and then.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if ($urandom_range(99) == 0)
                stall_mode = $urandom_range(3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(3) == 0);
                2: out_stall <= ($urandom_range(1) == 0);
                default: out_stall <= ($urandom_range(9) != 0);
            endcase
        end
    end

    // Send one request; gaps come between bursts of random length.
    task automatic send(logic req_op, logic [43:0] sz, logic [43:0] addr);
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 1);
            repeat ($urandom_range(6)) @(negedge clk);
        end
        burst_left--;
        in_valid       = 1'b1;
        op             = req_op;
        size_bytes     = sz;
        region_address = addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req_op, sz, addr);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [43:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_window(logic [43:0] b, logic [43:0] l);
        drain();
        write_reg(CFG_BASE, b);
        write_reg(CFG_LENGTH, l);
    endtask

    // Random mix; sizes scale with the window so it fills and frees.
    task automatic random_phase(int count, logic [43:0] unit);
        logic [43:0] sz;
        logic [43:0] a;
        int          k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 50) begin
                sz = 44'($urandom_range(4, 1)) * unit - 44'($urandom_range(8191));
                if ($urandom_range(19) == 0)
                    sz = 44'({$urandom, $urandom});
                send(OP_ALLOC, sz, 44'({$urandom, $urandom}));
            end else if (k < 90) begin
                send(OP_RELEASE, 44'({$urandom, $urandom}), sb.some_start());
            end else begin
                a = 44'({$urandom, $urandom});
                if ($urandom_range(2) == 0)
                    a = 44'h0;
                send(OP_RELEASE, 44'({$urandom, $urandom}), a);
            end
        end
    endtask

    initial
    begin
        sb         = new();
        burst_left = 0;
        stall_mode = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BASE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        op             = OP_ALLOC;
        size_bytes     = '0;
        region_address = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero window, then a small window.
        send(OP_ALLOC, 44'h1000, 44'h0);
        set_window(44'h0010000, 44'h0100000);
        send(OP_ALLOC, 44'h0, 44'h0);
        send(OP_ALLOC, 44'hFFFFFFFFFFF, 44'h0);
        send(OP_ALLOC, 44'h0100001, 44'h0);
        send(OP_ALLOC, 44'h1, 44'h0);
        send(OP_ALLOC, 44'h2000, 44'h0);
        send(OP_ALLOC, 44'h00FC000, 44'h0);
        send(OP_RELEASE, 44'h0, 44'h0);
        send(OP_RELEASE, 44'h0, 44'h0010001);
        send(OP_RELEASE, 44'h0, 44'hFFFFFFFE000);
        send(OP_RELEASE, 44'h0, 44'h0010000);
        send(OP_ALLOC, 44'h0010000, 44'h0);
        send(OP_RELEASE, 44'hFFFFFFFFFFF, 44'h0010000);
        // Fill the table to its limit.
        set_window(44'h0, 44'hFFFFFFFFFFF);
        for (int i = 0; i < 34; i++)
            send(OP_ALLOC, 44'h2000, 44'h0);
        send(OP_ALLOC, 44'hFFFFFFFFFFF, 44'h0);
        // Hold off until all results arrive.
        while (sb.pending() != 0)
            @(negedge clk);
        for (int i = 0; i < 10; i++)
            send(OP_RELEASE, 44'h0, sb.some_start());

        // Random phases across windows, extremes included.
        set_window(44'h0100000, 44'h0040000);
        random_phase(300, 44'h2000);
        set_window(44'hFFFFFF00000, 44'hFFFFFFFFFFF);
        random_phase(300, 44'h0008000);
        set_window(44'h0, 44'h0400000);
        random_phase(300, 44'h0006000);
        set_window(44'hABCDE000000, 44'h0000000A000);
        random_phase(300, 44'h2000);

        drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
